FILE: src/rmms_pkg.sv
// ----------------------------------------------------------------------------
// rmms_pkg
// Shared constants and types of the running min / max / mean statistics core.
// ----------------------------------------------------------------------------
package rmms_pkg;

  localparam int CHANNELS_DEF     = 4;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 16;

  localparam int MAX_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int COLOUR_W     = 2;
  localparam int NUM_COLOURS  = 3;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  localparam logic [COLOUR_W-1:0] COLOUR_NONE  = 2'd0;
  localparam logic [COLOUR_W-1:0] COLOUR_RED   = 2'd1;
  localparam logic [COLOUR_W-1:0] COLOUR_GREEN = 2'd2;
  localparam logic [COLOUR_W-1:0] COLOUR_BLUE  = 2'd3;

  typedef struct packed {
    logic                clear;
    logic                update;
    logic [COLOUR_W-1:0] colour;
  } colour_ctrl_t;

endpackage

FILE: src/rmms_in_if.sv
// ----------------------------------------------------------------------------
// rmms_in_if
// Input channel: one word carries a sample set with its colour, or a clear.
// ----------------------------------------------------------------------------
interface rmms_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [SAMPLE_WIDTH-1:0] sample_0;
  logic [SAMPLE_WIDTH-1:0] sample_1;
  logic [SAMPLE_WIDTH-1:0] sample_2;
  logic [SAMPLE_WIDTH-1:0] sample_3;
  logic [1:0]              colour;

  modport source (
    output valid, kind, sample_0, sample_1, sample_2, sample_3, colour,
    input  ready
  );

  modport sink (
    input  valid, kind, sample_0, sample_1, sample_2, sample_3, colour,
    output ready
  );
endinterface

FILE: src/rmms_out_if.sv
// ----------------------------------------------------------------------------
// rmms_out_if
// Result channel: one word carries the statistics of one channel.
// ----------------------------------------------------------------------------
interface rmms_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              channel;
  logic [SAMPLE_WIDTH-1:0] max_value;
  logic [SAMPLE_WIDTH-1:0] min_value;
  logic [SAMPLE_WIDTH-1:0] mean_value;
  logic [1:0]              dominant;
  logic                    last;

  modport source (
    output valid, channel, max_value, min_value, mean_value, dominant, last,
    input  ready
  );

  modport sink (
    input  valid, channel, max_value, min_value, mean_value, dominant, last,
    output ready
  );
endinterface

FILE: src/rmms_div.sv
// ----------------------------------------------------------------------------
// rmms_div
// Bit-serial restoring divider: signed sum over unsigned count, truncated
// toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmms_div
  import rmms_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [SAMPLE_WIDTH+COUNT_WIDTH-1:0]  dividend,
  input  logic [COUNT_WIDTH-1:0]               divisor,
  output logic                                 done,
  output logic [SAMPLE_WIDTH-1:0]              quotient
);

  localparam int SUM_WIDTH = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int ITER_W    = $clog2(SAMPLE_WIDTH);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(SAMPLE_WIDTH - 1);

  logic                    busy;
  logic [ITER_W-1:0]       iter;
  logic                    neg;
  logic [COUNT_WIDTH-1:0]  den;
  logic [COUNT_WIDTH-1:0]  rem;
  logic [SAMPLE_WIDTH-1:0] shift;
  logic [SUM_WIDTH-1:0]    mag;
  logic [COUNT_WIDTH:0]    trial;
  logic [COUNT_WIDTH:0]    diff;
  logic                    take;

  // The quotient magnitude never exceeds the sample range, so the upper part
  // of the dividend is already below the divisor and seeds the remainder.
  always_comb begin
    mag   = dividend[SUM_WIDTH-1] ? (~dividend + SUM_WIDTH'(1)) : dividend;
    trial = {rem, shift[SAMPLE_WIDTH-1]};
    diff  = trial - {1'b0, den};
    take  = ~diff[COUNT_WIDTH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= !start && busy && (iter == LAST_ITER);
      if (start) begin
        busy  <= 1'b1;
        iter  <= '0;
        neg   <= dividend[SUM_WIDTH-1];
        den   <= divisor;
        rem   <= mag[SUM_WIDTH-1:SAMPLE_WIDTH];
        shift <= mag[SAMPLE_WIDTH-1:0];
      end else if (busy) begin
        rem   <= take ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
        shift <= {shift[SAMPLE_WIDTH-2:0], take};
        iter  <= iter + ITER_W'(1);
        if (iter == LAST_ITER) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = neg ? (~shift + SAMPLE_WIDTH'(1)) : shift;

endmodule

FILE: src/rmms_colour.sv
// ----------------------------------------------------------------------------
// rmms_colour
// Saturating red, green and blue report counters and the dominant colour.
// ----------------------------------------------------------------------------
module rmms_colour
  import rmms_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  colour_ctrl_t        ctrl,
  output logic [COLOUR_W-1:0] dominant
);

  logic [COUNT_WIDTH-1:0] counts [NUM_COLOURS];
  logic [COUNT_WIDTH-1:0] best;
  logic [COLOUR_W-1:0]    pick;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
        counts[i] <= '0;
      end
    end else if (ctrl.update) begin
      for (int i = 0; i < NUM_COLOURS; i++) begin
        if (ctrl.colour == COLOUR_W'(i + 1) && counts[i] != '1) begin
          counts[i] <= counts[i] + COUNT_WIDTH'(1);
        end
      end
    end
  end

  // The first colour wins a tie.
  always_comb begin
    best = counts[0];
    pick = COLOUR_RED;
    if (counts[1] > best) begin
      best = counts[1];
      pick = COLOUR_GREEN;
    end
    if (counts[2] > best) begin
      best = counts[2];
      pick = COLOUR_BLUE;
    end
    dominant = (best == '0) ? COLOUR_NONE : pick;
  end

endmodule

FILE: src/running_min_max_mean_stats_core.sv
// ----------------------------------------------------------------------------
// running_min_max_mean_stats_core
// Each channel's mean comes from the shared bit-serial divider, one channel
// after another, so a sample word occupies the core until its last channel's
// result word is registered; the input is not ready meanwhile, and a stalled
// result channel holds the core. A clear word yields no result. Reset clears
// the statistics, the colour counters and the control state.
// ----------------------------------------------------------------------------
module running_min_max_mean_stats_core
  import rmms_pkg::*;
#(
  parameter int CHANNELS     = CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  rmms_in_if.sink    samples,
  rmms_out_if.source results
);

  localparam int SUM_WIDTH = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_OUTPUT = 5'b10000
  } state_t;

  state_t                         state;
  logic [CH_W-1:0]                ch;
  logic [COUNT_WIDTH-1:0]         count;
  logic                           counting;
  logic signed [SAMPLE_WIDTH-1:0] samp_q [MAX_CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] ch_max [MAX_CHANNELS];
  logic signed [SAMPLE_WIDTH-1:0] ch_min [MAX_CHANNELS];
  logic signed [SUM_WIDTH-1:0]    ch_sum [MAX_CHANNELS];

  logic                    o_valid;
  logic [CH_W-1:0]         o_ch;
  logic [SAMPLE_WIDTH-1:0] o_max;
  logic [SAMPLE_WIDTH-1:0] o_min;
  logic [SAMPLE_WIDTH-1:0] o_mean;
  logic [COLOUR_W-1:0]     o_dom;
  logic                    o_last;

  logic                           acc;
  logic signed [SAMPLE_WIDTH-1:0] v;
  logic signed [SUM_WIDTH-1:0]    sum_next;
  logic                           div_done;
  logic [SAMPLE_WIDTH-1:0]        div_q;
  logic [COLOUR_W-1:0]            dominant;
  colour_ctrl_t                   colour_ctrl;

  assign samples.ready = (state == ST_IDLE);
  assign acc           = samples.valid && samples.ready;

  always_comb begin
    v        = samp_q[ch];
    sum_next = ch_sum[ch] + {{COUNT_WIDTH{v[SAMPLE_WIDTH-1]}}, v};
    colour_ctrl.clear  = acc && (samples.kind == KIND_CLEAR);
    colour_ctrl.update = acc && (samples.kind == KIND_SAMPLE);
    colour_ctrl.colour = samples.colour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ch       <= '0;
      count    <= '0;
      counting <= 1'b0;
      o_valid  <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        ch_max[i] <= SMIN;
        ch_min[i] <= SMAX;
        ch_sum[i] <= '0;
      end
    end else begin
      if (results.valid && results.ready && state != ST_OUTPUT) begin
        o_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (samples.kind == KIND_CLEAR) begin
              count <= '0;
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                ch_max[i] <= SMIN;
                ch_min[i] <= SMAX;
                ch_sum[i] <= '0;
              end
            end else begin
              samp_q[0] <= samples.sample_0;
              samp_q[1] <= samples.sample_1;
              samp_q[2] <= samples.sample_2;
              samp_q[3] <= samples.sample_3;
              counting  <= (count != CMAX);
              if (count != CMAX) begin
                count <= count + COUNT_WIDTH'(1);
              end
              ch    <= '0;
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          if (v > ch_max[ch]) begin
            ch_max[ch] <= v;
          end
          if (v < ch_min[ch]) begin
            ch_min[ch] <= v;
          end
          if (counting) begin
            ch_sum[ch] <= sum_next;
          end
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_OUTPUT;
          end
        end
        ST_OUTPUT: begin
          if (!o_valid || results.ready) begin
            o_valid <= 1'b1;
            o_ch    <= ch;
            o_max   <= ch_max[ch];
            o_min   <= ch_min[ch];
            o_mean  <= div_q;
            o_dom   <= dominant;
            o_last  <= (ch == LAST_CH);
            if (ch == LAST_CH) begin
              state <= ST_IDLE;
            end else begin
              ch    <= ch + CH_W'(1);
              state <= ST_UPDATE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  rmms_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_LOAD),
    .dividend (ch_sum[ch]),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  rmms_colour #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_colour (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (colour_ctrl),
    .dominant (dominant)
  );

  assign results.valid      = o_valid;
  assign results.channel    = o_ch;
  assign results.max_value  = o_max;
  assign results.min_value  = o_min;
  assign results.mean_value = o_mean;
  assign results.dominant   = o_dom;
  assign results.last       = o_last;

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.last |-> results.channel == LAST_CH)
    else $error("last word does not belong to the final channel");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    !(acc && samples.kind == KIND_CLEAR) |=> count >= $past(count))
    else $error("sample count went down without a clear");

  a_max_above_min: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUTPUT && count != '0 |-> ch_max[ch] >= ch_min[ch])
    else $error("channel maximum below its minimum");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of running_min_max_mean_stats_core. A table of directed words
// (extremes, clears, colour ties, truncation of negative means) is followed by
// random sample and clear words. Both sides idle at random and the receiver
// once holds off long enough to stall the input. Every result word is checked
// field by field against a predictor of the running statistics.
// ----------------------------------------------------------------------------
module tb_top;
  import rmms_pkg::*;

  localparam int SW            = SAMPLE_WIDTH_DEF;
  localparam int NCH           = CHANNELS_DEF;
  localparam int RAND_WORDS    = 93;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 160;
  localparam int WATCH_LIMIT   = 5000;
  localparam int REPORT_LINES  = 40;

  localparam logic [SW-1:0] SMIN = 16'h8000;
  localparam logic [SW-1:0] SMAX = 16'h7fff;
  localparam logic [15:0]   CNT_TOP = 16'hffff;

  typedef struct packed {
    logic          kind;
    logic [SW-1:0] s0;
    logic [SW-1:0] s1;
    logic [SW-1:0] s2;
    logic [SW-1:0] s3;
    logic [1:0]    colour;
    logic          fresh;
  } stim_row_t;

  typedef struct packed {
    logic [1:0]    channel;
    logic [SW-1:0] max_value;
    logic [SW-1:0] min_value;
    logic [SW-1:0] mean_value;
    logic [1:0]    dominant;
    logic          last;
  } stats_word_t;

  localparam int DIR_ROWS = 17;

  // A row marked fresh follows reset or a clear, so each channel's max, min
  // and mean equal its sample and the dominant colour equals the colour.
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_SAMPLE, SMIN,     SMIN,     SMIN,     SMIN,     COLOUR_NONE,  1'b1},
    '{KIND_SAMPLE, SMAX,     SMIN,     16'h0000, 16'hffff, COLOUR_RED,   1'b0},
    '{KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, COLOUR_GREEN, 1'b0},
    '{KIND_SAMPLE, 16'h5555, 16'haaaa, 16'h00ff, 16'hff00, COLOUR_BLUE,  1'b0},
    '{KIND_CLEAR,  16'h1234, 16'hfedc, SMAX,     SMIN,     COLOUR_BLUE,  1'b0},
    '{KIND_SAMPLE, SMAX,     SMAX,     SMAX,     SMAX,     COLOUR_RED,   1'b1},
    '{KIND_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, COLOUR_NONE,  1'b0},
    '{KIND_CLEAR,  16'hffff, 16'hffff, 16'hffff, 16'hffff, COLOUR_RED,   1'b0},
    '{KIND_SAMPLE, 16'h0001, 16'hffff, 16'h0002, 16'hfffe, COLOUR_GREEN, 1'b1},
    '{KIND_SAMPLE, 16'hfffc, 16'h0004, 16'hfffb, 16'h0005, COLOUR_RED,   1'b0},
    '{KIND_SAMPLE, 16'hfffc, 16'h0004, 16'hfffb, 16'h0005, COLOUR_NONE,  1'b0},
    '{KIND_CLEAR,  16'haaaa, 16'h5555, 16'haaaa, 16'h5555, COLOUR_GREEN, 1'b0},
    '{KIND_SAMPLE, 16'hfffd, 16'h0003, 16'hffff, 16'h0001, COLOUR_NONE,  1'b1},
    '{KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, COLOUR_BLUE,  1'b0},
    '{KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, COLOUR_BLUE,  1'b0},
    '{KIND_SAMPLE, SMAX,     SMIN,     SMAX,     SMIN,     COLOUR_GREEN, 1'b0},
    '{KIND_SAMPLE, SMIN,     SMAX,     SMIN,     SMAX,     COLOUR_BLUE,  1'b0}
  };

  logic clk;
  logic rst;

  rmms_in_if  #(.SAMPLE_WIDTH(SW)) samples_if ();
  rmms_out_if #(.SAMPLE_WIDTH(SW)) results_if ();

  running_min_max_mean_stats_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  logic [15:0]          n_samples;
  longint               ch_sum  [NCH];
  logic signed [SW-1:0] ch_hi   [NCH];
  logic signed [SW-1:0] ch_lo   [NCH];
  logic signed [SW-1:0] ch_avg  [NCH];
  logic [15:0]          hue_cnt [3];
  logic [1:0]           lead_colour;

  stats_word_t pending_stats [$];
  int          err_count;
  int          tx_words;
  bit          tx_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < REPORT_LINES) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  task automatic clear_stats();
    n_samples = '0;
    for (int i = 0; i < NCH; i++) begin
      ch_sum[i] = 0;
      ch_hi[i]  = SMIN;
      ch_lo[i]  = SMAX;
      ch_avg[i] = '0;
    end
    for (int i = 0; i < 3; i++) hue_cnt[i] = '0;
    lead_colour = COLOUR_NONE;
  endtask

  task automatic update_stats(input stim_row_t w);
    logic signed [SW-1:0] v [NCH];
    logic [15:0]          best;
    int                   idx;
    bit                   counting;
    stats_word_t          r;
    v[0] = w.s0;
    v[1] = w.s1;
    v[2] = w.s2;
    v[3] = w.s3;
    counting = (n_samples != CNT_TOP);
    if (counting) n_samples = n_samples + 16'd1;
    for (int i = 0; i < NCH; i++) begin
      if (v[i] > ch_hi[i]) ch_hi[i] = v[i];
      if (v[i] < ch_lo[i]) ch_lo[i] = v[i];
      if (counting) begin
        ch_sum[i] = ch_sum[i] + longint'(v[i]);
        ch_avg[i] = SW'(ch_sum[i] / longint'(n_samples));
      end
    end
    if (w.colour != COLOUR_NONE && hue_cnt[w.colour - 2'd1] != CNT_TOP) begin
      hue_cnt[w.colour - 2'd1] = hue_cnt[w.colour - 2'd1] + 16'd1;
    end
    best = hue_cnt[0];
    idx  = 0;
    for (int i = 1; i < 3; i++) begin
      if (hue_cnt[i] > best) begin
        best = hue_cnt[i];
        idx  = i;
      end
    end
    lead_colour = (best == 0) ? COLOUR_NONE : 2'(idx + 1);
    for (int i = 0; i < NCH; i++) begin
      r.channel  = 2'(i);
      r.last     = (i == NCH - 1);
      if (w.fresh) begin
        r.max_value  = v[i];
        r.min_value  = v[i];
        r.mean_value = v[i];
        r.dominant   = w.colour;
      end else begin
        r.max_value  = ch_hi[i];
        r.min_value  = ch_lo[i];
        r.mean_value = ch_avg[i];
        r.dominant   = lead_colour;
      end
      pending_stats.push_back(r);
    end
  endtask

  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [SW-1:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return SMIN;
      1: return SMAX;
      2: return SW'($urandom_range(0, 16) - 8);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic stim_row_t draw_word();
    stim_row_t w;
    w.kind   = ($urandom_range(0, 99) < 6) ? KIND_CLEAR : KIND_SAMPLE;
    w.s0     = draw_sample();
    w.s1     = draw_sample();
    w.s2     = draw_sample();
    w.s3     = draw_sample();
    w.colour = 2'($urandom_range(0, 3));
    w.fresh  = 1'b0;
    return w;
  endfunction

  task automatic send_word(input stim_row_t w);
    int gap;
    if (tx_words % 12 == 0) tx_calm = ($urandom_range(0, 9) < 3);
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid    <= 1'b1;
    samples_if.kind     <= w.kind;
    samples_if.sample_0 <= w.s0;
    samples_if.sample_1 <= w.s1;
    samples_if.sample_2 <= w.s2;
    samples_if.sample_3 <= w.s3;
    samples_if.colour   <= w.colour;
    do @(posedge clk); while (!samples_if.ready);
    if (w.kind == KIND_CLEAR) clear_stats();
    else update_stats(w);
    tx_words++;
  endtask

  initial begin
    rst                 <= 1'b1;
    samples_if.valid    <= 1'b0;
    samples_if.kind     <= KIND_SAMPLE;
    samples_if.sample_0 <= '0;
    samples_if.sample_1 <= '0;
    samples_if.sample_2 <= '0;
    samples_if.sample_3 <= '0;
    samples_if.colour   <= COLOUR_NONE;
    err_count = 0;
    tx_words  = 0;
    tx_calm   = 1'b0;
    clear_stats();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < DIR_ROWS; k++) send_word(dir_rows[k]);
    for (int k = 0; k < RAND_WORDS; k++) send_word(draw_word());
    samples_if.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS running_min_max_mean_stats_core");
    end else begin
      $display("FAIL running_min_max_mean_stats_core");
    end
    $finish;
  end

  initial begin
    int          gap;
    int          taken;
    bit          rx_calm;
    stats_word_t want;
    results_if.ready <= 1'b0;
    taken   = 0;
    rx_calm = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 12 == 0) rx_calm = ($urandom_range(0, 9) < 3);
      // One long hold-off lets the core fill up and stall its input.
      gap = (taken == 40) ? HOLD_CYCLES : pick_gap(rx_calm);
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      taken++;
      if (pending_stats.size() == 0) begin
        report_mismatch("word with nothing pending", 32'(results_if.channel), 32'd0);
      end else begin
        want = pending_stats.pop_front();
        if (results_if.channel !== want.channel)
          report_mismatch("channel", 32'(results_if.channel), 32'(want.channel));
        if (results_if.max_value !== want.max_value)
          report_mismatch("max_value", 32'(results_if.max_value), 32'(want.max_value));
        if (results_if.min_value !== want.min_value)
          report_mismatch("min_value", 32'(results_if.min_value), 32'(want.min_value));
        if (results_if.mean_value !== want.mean_value)
          report_mismatch("mean_value", 32'(results_if.mean_value),
                          32'(want.mean_value));
        if (results_if.dominant !== want.dominant)
          report_mismatch("dominant", 32'(results_if.dominant), 32'(want.dominant));
        if (results_if.last !== want.last)
          report_mismatch("last", 32'(results_if.last), 32'(want.last));
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("timeout after %0d cycles without a word moving", idle_cycles);
        $display("FAIL running_min_max_mean_stats_core");
        $finish;
      end
    end
  end

endmodule

FILE: filelist.f
src/rmms_pkg.sv
src/rmms_in_if.sv
src/rmms_out_if.sv
src/rmms_div.sv
src/rmms_colour.sv
src/running_min_max_mean_stats_core.sv
sim/tb_top.sv
